[hdl/mpid_pkg.sv]
// Shared types, constants and gain table for the multichannel positional PID block.
package mpid_pkg;

  // Channel configuration
  localparam int CHANNELS       = 5;
  localparam int CH_IW          = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PWM_CHANNELS   = 3;   // channels below this use the /100 PWM path
  localparam int CH_ANGLE       = 3;   // error folded into +-180.00 degrees
  localparam int CH_SEED        = 4;   // init request seeds the last measurement

  // Gain format
  localparam int GAIN_FRAC_BITS = 16;
  localparam int GW             = GAIN_FRAC_BITS + 10;

  // Angle folding, hundredths of a degree
  localparam int ANGLE_HALF     = 18000;
  localparam int ANGLE_FULL     = 36000;

  // Datapath widths
  localparam int ERR_W  = 17;
  localparam int INT_W  = 32;
  localparam int PKP_W  = ERR_W + GW + 1;
  localparam int PKI_W  = INT_W + GW + 1;
  localparam int PKD_W  = ERR_W + GW + 1;
  localparam int ACC_W  = PKI_W + 2;
  localparam int T_W    = ACC_W - GAIN_FRAC_BITS;

  // Output scaling: drive magnitude never needs more than 15 bits
  localparam int Q_W        = 15;
  localparam int QMAX       = 2 ** Q_W;
  localparam int PWM_DIV    = 100;
  localparam int PWM_T_MAX  = PWM_DIV * QMAX;
  localparam int TL_W       = $clog2(PWM_T_MAX);
  localparam int DIV_K      = 29;
  localparam int DIV_M      = (2 ** DIV_K + PWM_DIV - 1) / PWM_DIV;
  localparam int DM_W       = $clog2(DIV_M + 1);
  localparam int DP_W       = TL_W + DM_W;

  // Queues
  localparam int QD         = 2;
  localparam int QPW        = $clog2(QD);
  localparam int QCW        = $clog2(QD + 1);
  localparam int OQD        = 2;
  localparam int OQPW       = $clog2(OQD);
  localparam int OQCW       = $clog2(OQD + 1);
  localparam int BACK_STAGES = 4;
  localparam int CAPACITY   = QD + BACK_STAGES + OQD;

  // Configuration register reset values
  localparam logic [15:0] BAND_RST = 16'd1500;
  localparam logic [14:0] PWM_RST  = 15'd50;
  localparam logic [14:0] RATE_RST = 15'd15000;

  typedef enum logic [1:0] {
    CFG_BAND = 2'd0,
    CFG_PWM  = 2'd1,
    CFG_RATE = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    FUNC_COMPUTE = 1'b0,
    FUNC_INIT    = 1'b1
  } func_e;

  // Gains, rounded to nearest
  localparam logic [GW-1:0] KP_01 = GW'(64'd15 << GAIN_FRAC_BITS);
  localparam logic [GW-1:0] KI_01 = GW'(((64'd1 << GAIN_FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [GW-1:0] KD_01 = GW'(64'd100 << GAIN_FRAC_BITS);
  localparam logic [GW-1:0] KP_2  = GW'(((64'd5 << GAIN_FRAC_BITS) + 64'd2) / 64'd4);
  localparam logic [GW-1:0] KD_2  = GW'(((64'd25 << GAIN_FRAC_BITS) + 64'd1) / 64'd2);
  localparam logic [GW-1:0] KP_3  = GW'(((64'd3 << GAIN_FRAC_BITS) + 64'd1) / 64'd2);
  localparam logic [GW-1:0] KD_3  = GW'(64'd18 << GAIN_FRAC_BITS);
  localparam logic [GW-1:0] KP_4  = GW'(64'd10 << GAIN_FRAC_BITS);
  localparam logic [GW-1:0] KD_4  = GW'(64'd400 << GAIN_FRAC_BITS);

  typedef struct packed {
    logic [GW-1:0] kp;
    logic [GW-1:0] ki;
    logic [GW-1:0] kd;
  } gain_t;

  // Request handed from front to back
  typedef struct packed {
    logic                    zero;   // init request or bad channel
    logic                    pwm;    // /100 path with PWM limit
    logic [2:0]              ch;
    logic signed [ERR_W-1:0] err;
    logic signed [INT_W-1:0] ival;   // integral, zero when out of band
    logic signed [ERR_W-1:0] dm;     // last minus current measurement
  } mid_item_t;

  function automatic gain_t gains_of(input logic [2:0] ch);
    gain_t g;
    g = '0;
    unique case (ch)
      3'd0, 3'd1: g = '{kp: KP_01, ki: KI_01, kd: KD_01};
      3'd2:       g = '{kp: KP_2,  ki: '0,    kd: KD_2};
      3'd3:       g = '{kp: KP_3,  ki: '0,    kd: KD_3};
      3'd4:       g = '{kp: KP_4,  ki: '0,    kd: KD_4};
      default:    g = '0;
    endcase
    return g;
  endfunction

endpackage

[hdl/multichannel_positional_pid.sv]
// Path: an accepted request is written to the request queue, passes the four-stage
//   multiply/scale pipeline and then the result queue, from which it is popped.
// Throughput: one request per cycle unless a full result queue stalls the pipeline;
//   the two-entry request and result queues keep both sides moving independently.
// Reset (rst_ni low, asynchronous): integrals and last measurements clear to zero,
//   registers return to band 1500, PWM limit 50, rate limit 15000, both queues empty.
module multichannel_positional_pid (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request side
  input  logic               push,
  output logic               full,
  input  logic               func_i,
  input  logic [2:0]         channel_i,
  input  logic signed [15:0] target_i,
  input  logic signed [15:0] measured_i,
  // result side
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] drive_o,
  // configuration
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i
);
  import mpid_pkg::*;

  // Configuration registers: user keeps static while requests in flight; unenforced.
  logic [15:0] band_q;
  logic [14:0] pwm_limit_q, rate_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_q       <= BAND_RST;
      pwm_limit_q  <= PWM_RST;
      rate_limit_q <= RATE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BAND: band_q       <= cfg_data_i;
        CFG_PWM:  pwm_limit_q  <= cfg_data_i[14:0];
        CFG_RATE: rate_limit_q <= cfg_data_i[14:0];
        default:  ;
      endcase
    end
  end

  // Front: the request is accepted whenever the middle queue has room.
  // State (integral, last measurement) is updated in the accept cycle, so a
  // following request on the same channel sees it without forwarding.
  logic      accept;
  mid_item_t front_item, back_item;
  logic      q_empty, q_take;

  assign accept = push && !full;

  mpid_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .func_i     (func_i),
    .channel_i  (channel_i),
    .target_i   (target_i),
    .measured_i (measured_i),
    .band_i     (band_q),
    .item_o     (front_item)
  );

  mpid_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (q_take),
    .item_o  (back_item),
    .empty_o (q_empty)
  );

  // Back: gain products, sum, divide (shift, plus reciprocal multiply for
  // the /100 channels), clamp; stalls only when its result queue is full.
  mpid_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (!q_empty),
    .item_i       (back_item),
    .take_o       (q_take),
    .pwm_limit_i  (pwm_limit_q),
    .rate_limit_i (rate_limit_q),
    .pop_i        (pop),
    .empty_o      (empty),
    .drive_o      (drive_o)
  );

endmodule

[hdl/mpid_front.sv]
// Front end: per-channel state update and request classification.
module mpid_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic                func_i,
  input  logic [2:0]          channel_i,
  input  logic signed [15:0]  target_i,
  input  logic signed [15:0]  measured_i,
  input  logic [15:0]         band_i,
  output mpid_pkg::mid_item_t item_o
);
  import mpid_pkg::*;

  logic signed [INT_W-1:0] integral_q [CHANNELS];
  logic signed [15:0]      prev_q     [CHANNELS];

  logic [CH_IW-1:0]        idx;
  logic                    bad, init;
  logic signed [INT_W-1:0] int_rd;
  logic signed [15:0]      prev_rd;
  logic signed [17:0]      diff, err18, bandp;
  logic                    in_band;
  logic signed [INT_W:0]   s_wide;
  logic signed [INT_W-1:0] s_sat;

  assign idx     = channel_i[CH_IW-1:0];
  assign bad     = ({1'b0, channel_i} >= 4'(CHANNELS));
  assign init    = (func_i == FUNC_INIT);
  assign int_rd  = bad ? '0 : integral_q[idx];
  assign prev_rd = bad ? '0 : prev_q[idx];

  always_comb begin
    diff = 18'(target_i) - 18'(measured_i);
    err18 = diff;
    if (channel_i == 3'(CH_ANGLE)) begin
      if (diff > 18'(ANGLE_HALF)) begin
        err18 = diff - 18'(ANGLE_FULL);
      end else if (diff < -18'(ANGLE_HALF)) begin
        err18 = diff + 18'(ANGLE_FULL);
      end
    end
  end

  assign bandp   = $signed({2'b00, band_i});
  assign in_band = (err18 <= bandp) && (err18 >= -bandp);

  assign s_wide = (INT_W + 1)'(int_rd) + (INT_W + 1)'(err18);
  always_comb begin
    if (s_wide[INT_W] != s_wide[INT_W-1]) begin
      s_sat = s_wide[INT_W] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
    end else begin
      s_sat = s_wide[INT_W-1:0];
    end
  end

  always_comb begin
    item_o.zero = bad || init;
    item_o.pwm  = (channel_i < 3'(PWM_CHANNELS));
    item_o.ch   = channel_i;
    item_o.err  = err18[ERR_W-1:0];
    item_o.ival = in_band ? s_sat : '0;
    item_o.dm   = ERR_W'(prev_rd) - ERR_W'(measured_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        integral_q[i] <= '0;
        prev_q[i]     <= '0;
      end
    end else if (accept_i && !bad) begin
      if (init) begin
        integral_q[idx] <= '0;
        prev_q[idx]     <= (channel_i == 3'(CH_SEED)) ? measured_i : '0;
      end else begin
        if (in_band) begin
          integral_q[idx] <= s_sat;
        end
        prev_q[idx] <= measured_i;
      end
    end
  end

endmodule

[hdl/mpid_queue.sv]
// Short request queue between front and back.
module mpid_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mpid_pkg::mid_item_t item_i,
  output logic                full_o,
  input  logic                pop_i,
  output mpid_pkg::mid_item_t item_o,
  output logic                empty_o
);
  import mpid_pkg::*;

  mid_item_t      mem_q [QD];
  logic [QPW-1:0] wptr_q, rptr_q;
  logic [QCW-1:0] cnt_q;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == QCW'(QD));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == QPW'(QD - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == QPW'(QD - 1)) ? '0 : rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + QCW'(do_push) - QCW'(do_pop);
    end
  end

endmodule

[hdl/mpid_back.sv]
// Back end: gain multiply, sum, scale, clamp pipeline and result queue.
module mpid_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  mpid_pkg::mid_item_t item_i,
  output logic                take_o,
  input  logic [14:0]         pwm_limit_i,
  input  logic [14:0]         rate_limit_i,
  input  logic                pop_i,
  output logic                empty_o,
  output logic signed [15:0]  drive_o
);
  import mpid_pkg::*;

  logic en;
  gain_t g;

  // stage 1: products
  logic                    v1_q, z1_q, p1_q;
  logic signed [PKP_W-1:0] pkp_q;
  logic signed [PKI_W-1:0] pki_q;
  logic signed [PKD_W-1:0] pkd_q;
  // stage 2: sum
  logic                    v2_q, z2_q, p2_q;
  logic signed [ACC_W-1:0] acc_q;
  // stage 3: magnitude, scale, coarse saturation
  logic                    v3_q, z3_q, p3_q, n3_q, s3_q;
  logic [TL_W-1:0]         tl_q;
  // stage 4: quotient
  logic                    v4_q, z4_q, p4_q, n4_q, s4_q;
  logic [Q_W-1:0]          q_q;

  logic [ACC_W-1:0]        mag;
  logic [T_W-1:0]          t;
  logic                    sat3;
  logic [DP_W-1:0]         dprod;
  logic [Q_W-1:0]          q4;
  logic [14:0]             lim, qm;
  logic signed [15:0]      drive_d;

  // result queue
  logic signed [15:0] omem_q [OQD];
  logic [OQPW-1:0]    owp_q, orp_q;
  logic [OQCW-1:0]    ocnt_q;
  logic               ofull, opush, opop;

  assign ofull  = (ocnt_q == OQCW'(OQD));
  assign en     = !(v4_q && ofull);
  assign take_o = en && valid_i;
  assign g      = gains_of(item_i.ch);

  assign mag  = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign t    = mag[ACC_W-1:GAIN_FRAC_BITS];
  assign sat3 = p2_q ? (t >= T_W'(PWM_T_MAX)) : (t >= T_W'(QMAX));

  assign dprod = DP_W'(tl_q) * DP_W'(DIV_M);
  assign q4    = p3_q ? dprod[DIV_K+Q_W-1:DIV_K] : tl_q[Q_W-1:0];

  always_comb begin
    lim = p4_q ? pwm_limit_i : rate_limit_i;
    qm  = (s4_q || (q_q > lim)) ? lim : q_q;
    if (z4_q) begin
      drive_d = '0;
    end else if (n4_q) begin
      drive_d = -$signed({1'b0, qm});
    end else begin
      drive_d = $signed({1'b0, qm});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      z1_q  <= item_i.zero;
      p1_q  <= item_i.pwm;
      pkp_q <= item_i.err * $signed({1'b0, g.kp});
      pki_q <= item_i.ival * $signed({1'b0, g.ki});
      pkd_q <= item_i.dm * $signed({1'b0, g.kd});
      z2_q  <= z1_q;
      p2_q  <= p1_q;
      acc_q <= ACC_W'(pkp_q) + ACC_W'(pki_q) + ACC_W'(pkd_q);
      z3_q  <= z2_q;
      p3_q  <= p2_q;
      n3_q  <= acc_q[ACC_W-1];
      s3_q  <= sat3;
      tl_q  <= t[TL_W-1:0];
      z4_q  <= z3_q;
      p4_q  <= p3_q;
      n4_q  <= n3_q;
      s4_q  <= s3_q;
      q_q   <= q4;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  assign opush   = v4_q && !ofull;
  assign opop    = pop_i && !empty_o;
  assign empty_o = (ocnt_q == '0);
  assign drive_o = omem_q[orp_q];

  always_ff @(posedge clk_i) begin
    if (opush) begin
      omem_q[owp_q] <= drive_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owp_q  <= '0;
      orp_q  <= '0;
      ocnt_q <= '0;
    end else begin
      if (opush) begin
        owp_q <= (owp_q == OQPW'(OQD - 1)) ? '0 : owp_q + 1'b1;
      end
      if (opop) begin
        orp_q <= (orp_q == OQPW'(OQD - 1)) ? '0 : orp_q + 1'b1;
      end
      ocnt_q <= ocnt_q + OQCW'(opush) - OQCW'(opop);
    end
  end

endmodule

[hdl/mpid_checker.sv]
// Port-level checker for the PID block and its bind.
module mpid_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic signed [15:0] drive_o
);
  import mpid_pkg::*;

  logic [7:0] outstanding_q;
  logic       in_acc, out_acc;

  assign in_acc  = push && !full;
  assign out_acc = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
    end else begin
      outstanding_q <= outstanding_q + 8'(in_acc) - 8'(out_acc);
    end
  end

  // no result without a request behind it
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (outstanding_q == 8'd0) |-> empty)
    else $error("result shown with no request outstanding");

  // in-flight requests never exceed the storage of the block
  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outstanding_q <= 8'(CAPACITY))
    else $error("more requests in flight than the block can hold");

  // reset leaves the result side empty
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result side not empty after reset");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(drive_o)))
    else $error("waiting result changed before pop");

endmodule

bind multichannel_positional_pid mpid_checker u_checker (.*);

[tb/pid_drive_checker.sv]
// Checker for the PID block: predicts each drive value from the accepted requests and compares.
`timescale 1ns / 100ps

module pid_drive_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic                full_i,
  input  mpid_pkg::func_e     func_i,
  input  logic [2:0]          channel_i,
  input  logic signed [15:0]  target_i,
  input  logic signed [15:0]  measured_i,
  input  logic                empty_i,
  input  logic                pop_i,
  input  logic signed [15:0]  drive_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  import mpid_pkg::*;

  localparam int TERM_P = 0;
  localparam int TERM_I = 1;
  localparam int TERM_D = 2;
  localparam longint SUM_MAX = 64'sd2147483647;
  localparam longint SUM_MIN = -64'sd2147483648;

  logic [15:0]        band_r;
  logic [14:0]        pwm_lim_r;
  logic [14:0]        rate_lim_r;
  int                 integ_sum [8];
  logic signed [15:0] last_meas [8];
  logic signed [15:0] due_drive [$];
  logic signed [15:0] want;
  int                 fails;

  // Rounded unsigned fixed-point gain of one term of one channel.
  function automatic longint gain_fx(input logic [2:0] ch, input int term);
    longint num;
    longint den;
    num = 0;
    den = 1;
    case (ch)
      3'd0, 3'd1: begin
        if (term == TERM_P) num = 15;
        else if (term == TERM_I) begin
          num = 1;
          den = 10;
        end else num = 100;
      end
      3'd2: begin
        if (term == TERM_P) begin
          num = 5;
          den = 4;
        end else if (term == TERM_D) begin
          num = 25;
          den = 2;
        end
      end
      3'd3: begin
        if (term == TERM_P) begin
          num = 3;
          den = 2;
        end else if (term == TERM_D) num = 18;
      end
      3'd4: begin
        if (term == TERM_P) num = 10;
        else if (term == TERM_D) num = 400;
      end
      default: num = 0;
    endcase
    return ((num <<< GAIN_FRAC_BITS) + den / 2) / den;
  endfunction

  // Drive value for one request; updates the channel's integral and last measurement.
  function automatic logic signed [15:0] pid_drive(input func_e fn, input logic [2:0] ch,
                                                   input logic signed [15:0] tgt,
                                                   input logic signed [15:0] meas);
    int     err;
    int     band;
    longint acc;
    longint sum;
    longint den;
    longint lim;
    longint q;
    if (ch >= CHANNELS) return '0;
    if (fn == FUNC_INIT) begin
      integ_sum[ch] = 0;
      last_meas[ch] = (ch == CH_SEED) ? meas : '0;
      return '0;
    end
    err = int'(tgt) - int'(meas);
    if (ch == CH_ANGLE) begin
      if (err > ANGLE_HALF) err = err - ANGLE_FULL;
      else if (err < -ANGLE_HALF) err = err + ANGLE_FULL;
    end
    acc = longint'(err) * gain_fx(ch, TERM_P);
    band = int'(band_r);
    if (err <= band && err >= -band) begin
      sum = longint'(integ_sum[ch]) + longint'(err);
      if (sum > SUM_MAX) sum = SUM_MAX;
      if (sum < SUM_MIN) sum = SUM_MIN;
      integ_sum[ch] = int'(sum);
      acc = acc + sum * gain_fx(ch, TERM_I);
    end
    acc = acc + longint'(int'(last_meas[ch]) - int'(meas)) * gain_fx(ch, TERM_D);
    last_meas[ch] = meas;
    den = 64'sd1 <<< GAIN_FRAC_BITS;
    if (ch < PWM_CHANNELS) begin
      den = den * PWM_DIV;
      lim = longint'(pwm_lim_r);
    end else begin
      lim = longint'(rate_lim_r);
    end
    q = acc / den;
    if (q > lim) q = lim;
    if (q < -lim) q = -lim;
    return 16'(q);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_r     = BAND_RST;
      pwm_lim_r  = PWM_RST;
      rate_lim_r = RATE_RST;
      for (int i = 0; i < 8; i++) begin
        integ_sum[i] = 0;
        last_meas[i] = '0;
      end
      due_drive.delete();
      fails = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // result side first: a request taken at this edge cannot be answered at it
      if (pop_i && !empty_i) begin
        if (due_drive.size() == 0) begin
          fails++;
          $error("drive: result with no request waiting, actual %0d", drive_i);
        end else begin
          want = due_drive.pop_front();
          if (drive_i !== want) begin
            fails++;
            $error("drive mismatch: expected %0d, actual %0d", want, drive_i);
          end
        end
      end
      if (push_i && !full_i)
        due_drive.push_back(pid_drive(func_i, channel_i, target_i, measured_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BAND: band_r = cfg_data_i;
          CFG_PWM:  pwm_lim_r = cfg_data_i[14:0];
          CFG_RATE: rate_lim_r = cfg_data_i[14:0];
          default:  ;
        endcase
      end
      pending_o    <= due_drive.size();
      fail_count_o <= fails;
    end
  end

endmodule

[tb/tb_multichannel_positional_pid.sv]
// Top of the PID testbench: clock, reset, request and pop stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module tb_multichannel_positional_pid;
  import mpid_pkg::*;

  localparam int          PHASES      = 8;
  localparam int          PHASE_ITEMS = 250;
  localparam int          HOLD_PHASE  = 4;     // phase that opens with a long pop hold-off
  localparam int          HOLD_CYCLES = 400;
  localparam int          SETTLE      = 10;    // settle margin after the drain
  localparam int          QUIET_LIMIT = 5000;  // cycles with nothing accepted
  localparam logic [1:0]  CFG_SPARE   = 2'd3;  // unmapped register index
  localparam logic signed [15:0] S_MAX = 16'sh7FFF;
  localparam logic signed [15:0] S_MIN = 16'sh8000;

  logic               clk      = 1'b0;
  logic               rst_n    = 1'b0;
  logic               push     = 1'b0;
  logic               full;
  func_e              func     = FUNC_COMPUTE;
  logic [2:0]         channel  = '0;
  logic signed [15:0] target   = '0;
  logic signed [15:0] measured = '0;
  logic               empty;
  logic               pop      = 1'b0;
  logic signed [15:0] drive;
  logic               cfg_we   = 1'b0;
  logic [1:0]         cfg_idx  = '0;
  logic [15:0]        cfg_data = '0;

  // Idling knobs: send_idle is only read by the stimulus process itself,
  // stall_pct and hold_req cross to the pop process and so change by NBA.
  int   send_idle    = 0;
  int   stall_pct    = 0;
  logic hold_req     = 1'b0;
  int   quiet_cycles = 0;
  int   last_m       = 0;  // measurement drift, keeps the derivative term moderate
  int   fail_count;
  int   pending;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  multichannel_positional_pid dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push       (push),
    .full       (full),
    .func_i     (func),
    .channel_i  (channel),
    .target_i   (target),
    .measured_i (measured),
    .empty      (empty),
    .pop        (pop),
    .drive_o    (drive),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  pid_drive_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .push_i       (push),
    .full_i       (full),
    .func_i       (func),
    .channel_i    (channel),
    .target_i     (target),
    .measured_i   (measured),
    .empty_i      (empty),
    .pop_i        (pop),
    .drive_i      (drive),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Offer one request, with random idle cycles ahead of it, and hold it until
  // taken. push is left high on return so back-to-back requests need no gap.
  task automatic send_request(input func_e fn, input logic [2:0] ch,
                              input logic signed [15:0] tgt,
                              input logic signed [15:0] meas);
    while (send_idle != 0 && $urandom_range(99, 0) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push     <= 1'b1;
    func     <= fn;
    channel  <= ch;
    target   <= tgt;
    measured <= meas;
    do @(posedge clk); while (full);
  endtask

  // Stop offering and wait for every outstanding drive, then let the pipe settle
  // so register writes only ever land on an idle block.
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write all three registers, then poke the unmapped index with junk.
  task automatic load_regs(input logic [15:0] band, input logic [15:0] pwm,
                           input logic [15:0] rate);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_BAND;
    cfg_data <= band;
    @(posedge clk);
    cfg_idx  <= CFG_PWM;
    cfg_data <= pwm;
    @(posedge clk);
    cfg_idx  <= CFG_RATE;
    cfg_data <= rate;
    @(posedge clk);
    cfg_idx  <= CFG_SPARE;
    cfg_data <= 16'($urandom);
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Random request: mostly valid channels and compute requests. A quarter use
  // fully random fields; the rest track a drifting measurement with the target
  // close by (in-band errors) or far off (angle folding, clamping).
  task automatic random_request();
    func_e              fn;
    logic [2:0]         ch;
    logic signed [15:0] tgt;
    logic signed [15:0] meas;
    int                 span;
    fn = ($urandom_range(99, 0) < 8) ? FUNC_INIT : FUNC_COMPUTE;
    if ($urandom_range(99, 0) < 10) ch = 3'($urandom_range(7, CHANNELS));
    else ch = 3'($urandom_range(CHANNELS - 1, 0));
    if ($urandom_range(3, 0) == 0) begin
      meas = 16'($urandom);
      tgt  = 16'($urandom);
    end else begin
      span = ($urandom_range(3, 0) == 0) ? 40000 : 3000;
      meas = 16'(last_m + int'($urandom_range(400, 0)) - 200);
      tgt  = 16'(int'(meas) + int'($urandom_range(2 * span, 0)) - span);
    end
    last_m = int'(meas);
    send_request(fn, ch, tgt, meas);
  endtask

  // Pop side: random stalls per stall_pct; one long hold-off, counted here,
  // while hold_req is up so the block fills and pushes back on the requests.
  initial begin
    int held;
    held = 0;
    forever begin
      @(posedge clk);
      if (hold_req && held < HOLD_CYCLES) begin
        pop <= 1'b0;
        held++;
      end else begin
        pop <= ($urandom_range(99, 0) >= stall_pct);
      end
    end
  end

  // Watchdog: too long without any request or result moving ends the run.
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_multichannel_positional_pid: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests at reset settings: band 1500, PWM limit 50, rate 15000.
    send_request(FUNC_COMPUTE, 3'd0, S_MAX, S_MIN);        // largest error
    send_request(FUNC_COMPUTE, 3'd0, S_MIN, S_MAX);        // most negative error
    send_request(FUNC_COMPUTE, 3'd1, 16'sd100, 16'sd0);    // in band
    send_request(FUNC_COMPUTE, 3'd1, -16'sd1500, 16'sd0);  // on the band edge
    send_request(FUNC_COMPUTE, 3'd1, 16'sd1501, 16'sd0);   // just out of band
    send_request(FUNC_COMPUTE, 3'd1, 16'sd0, 16'sd1500);   // edge, from the measurement
    send_request(FUNC_COMPUTE, 3'd2, 16'sd1000, 16'sd0);
    send_request(FUNC_COMPUTE, 3'd2, S_MAX, S_MIN);
    // angle channel: fold down, fold up, both limits unfolded, fold applied once
    send_request(FUNC_COMPUTE, 3'(CH_ANGLE), 16'sd20000, 16'sd0);
    send_request(FUNC_COMPUTE, 3'(CH_ANGLE), -16'sd20000, 16'sd0);
    send_request(FUNC_COMPUTE, 3'(CH_ANGLE), 16'sd18000, 16'sd0);
    send_request(FUNC_COMPUTE, 3'(CH_ANGLE), -16'sd18000, 16'sd0);
    send_request(FUNC_COMPUTE, 3'(CH_ANGLE), S_MAX, S_MIN);
    send_request(FUNC_COMPUTE, 3'(CH_ANGLE), S_MIN, S_MAX);
    // seeded channel: init keeps the measurement as the last value
    send_request(FUNC_COMPUTE, 3'(CH_SEED), 16'sd100, 16'sd50);
    send_request(FUNC_INIT, 3'(CH_SEED), 16'sd0, 16'sd12345);
    send_request(FUNC_COMPUTE, 3'(CH_SEED), 16'sd0, 16'sd12345);
    // other channels: init clears the last value to zero
    send_request(FUNC_INIT, 3'd0, S_MAX, 16'sd777);
    send_request(FUNC_COMPUTE, 3'd0, 16'sd0, 16'sd777);
    send_request(FUNC_INIT, 3'(CH_ANGLE), 16'sd0, S_MIN);
    send_request(FUNC_COMPUTE, 3'(CH_ANGLE), 16'sd0, 16'sd0);
    // channels past the last one answer zero and touch nothing
    send_request(FUNC_COMPUTE, 3'd5, S_MAX, S_MIN);
    send_request(FUNC_INIT, 3'd6, S_MIN, S_MAX);
    send_request(FUNC_COMPUTE, 3'd7, S_MIN, S_MAX);
    drain();

    // Integral wind-up: widest band, widest limits, then drive channel 1 with
    // the largest error one way and then back the other way, so the integral
    // term grows large in both signs and the output crosses the clamp.
    load_regs(16'hFFFF, 16'h7FFF, 16'h7FFF);
    send_request(FUNC_INIT, 3'd1, 16'sd0, 16'sd0);
    repeat (50) send_request(FUNC_COMPUTE, 3'd1, S_MAX, S_MIN);
    repeat (100) send_request(FUNC_COMPUTE, 3'd1, S_MIN, S_MAX);
    repeat (3) send_request(FUNC_COMPUTE, 3'd1, S_MAX, S_MIN);
    drain();

    // Random phases: each sets its registers on an idle block, then runs one
    // idling mode. The hold-off phase runs with the sender never idle.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin
          send_idle = 0;
          stall_pct <= 0;
        end
        1: begin
          send_idle = 76;
          stall_pct <= 0;
        end
        2: begin
          send_idle = 0;
          stall_pct <= 76;
        end
        default: begin
          send_idle = 24;
          stall_pct <= 24;
        end
      endcase
      hold_req <= (ph == HOLD_PHASE);
      case (ph)
        0: load_regs(BAND_RST, 16'(PWM_RST), 16'(RATE_RST));
        1: load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: load_regs(16'd0, 16'd0, 16'd0);
        3: load_regs(16'd3000, 16'd200, 16'd800);
        5: load_regs(16'd1500, 16'd1000, 16'd15000);
        6: load_regs(16'd200, 16'd32767, 16'd100);
        default: load_regs(16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      repeat (PHASE_ITEMS) random_request();
      drain();
    end

    if (fail_count == 0) begin
      $display("tb_multichannel_positional_pid: done, clean");
    end else begin
      $display("tb_multichannel_positional_pid: done, errors");
    end
    $finish;
  end

endmodule
